### hdl/lmps_pkg.sv
// Shared types and constants for the LED matrix pixel scanner.
`default_nettype none

package lmps_pkg;

    localparam int MATRIX_DIM    = 8;
    localparam int IDX_W         = 3;
    localparam int PERIOD_W      = 20;
    localparam int COORD_W       = 4;
    localparam int OPCODE_W      = 3;
    localparam int BURST_LEN     = 2 * MATRIX_DIM;
    localparam int BURST_CNT_W   = 4;

    localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RESET = 20'd1000;
    localparam logic [PERIOD_W-1:0] ELAPSED_MAX       = 20'hFFFFF;

    localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SET     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ALL_OFF = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_ALL_ON  = 3'd4;

    localparam logic [BURST_CNT_W-1:0] BURST_LAST = 4'd15;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_SHIFT = 1'b1
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;   // apply the accepted input item
        logic shift;  // advance the serial burst by one bit
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit;   // current input item starts a burst
        logic last;   // current burst bit is the sixteenth
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/lmps_ctrl.sv
// Controller state machine: accepts items and sequences the 16-bit serial burst.
`default_nettype none

module lmps_ctrl
    import lmps_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        m_tvalid  = (state_reg == ST_SHIFT);
        cmd.exec  = s_tvalid & s_tready;
        cmd.shift = m_tvalid & m_tready;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.exec && status.emit) begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (cmd.shift && status.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/lmps_datapath.sv
// Datapath: frame buffer, scan timer, drive registers and serial shifter.
`default_nettype none

module lmps_datapath
    import lmps_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [PERIOD_W-1:0] cfg_wr_data,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire logic [COORD_W-1:0]  pixel_bit,
    input  wire logic [COORD_W-1:0]  pixel_byte,
    input  wire dp_cmd_t             cmd,
    output dp_status_t               status,
    output logic                     serial_data,
    output logic                     latch
);

    logic [MATRIX_DIM-1:0]  fb_reg [MATRIX_DIM];
    logic [MATRIX_DIM-1:0]  fb_next [MATRIX_DIM];
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [PERIOD_W-1:0]    elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]       byte_idx_reg, byte_idx_next;
    logic [IDX_W-1:0]       bit_idx_reg, bit_idx_next;
    logic [MATRIX_DIM-1:0]  row_reg, row_next;
    logic [MATRIX_DIM-1:0]  col_reg, col_next;
    logic [BURST_LEN-1:0]   shift_reg, shift_next;
    logic [BURST_CNT_W-1:0] cnt_reg, cnt_next;

    logic [PERIOD_W-1:0]    elapsed_inc;
    logic                   step_due;
    logic [IDX_W-1:0]       bit_adv, byte_adv;
    logic [MATRIX_DIM-1:0]  row_rel, col_rel, row_step, col_step, fb_row;
    logic                   lit;
    logic                   coord_ok;
    logic [IDX_W-1:0]       wr_bit, wr_byte;

    // scan step, evaluated every cycle
    always_comb begin
        elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
        step_due    = (elapsed_inc > period_reg);
        bit_adv     = bit_idx_reg + 1'b1;
        byte_adv    = (bit_adv == '0) ? byte_idx_reg + 1'b1 : byte_idx_reg;
        row_rel     = row_reg & ~(8'b1 << byte_idx_reg);
        col_rel     = col_reg | (8'b1 << bit_idx_reg);
        fb_row      = fb_reg[byte_adv];
        lit         = fb_row[bit_adv];
        row_step    = lit ? (row_rel | (8'b1 << byte_adv)) : row_rel;
        col_step    = lit ? (col_rel & ~(8'b1 << bit_adv)) : col_rel;
        coord_ok    = (pixel_bit >= 4'd1) && (pixel_bit <= 4'd8) &&
                      (pixel_byte >= 4'd1) && (pixel_byte <= 4'd8);
        wr_bit      = IDX_W'(pixel_bit - 4'd1);
        wr_byte     = IDX_W'(pixel_byte - 4'd1);

        status.emit = (opcode == OP_TICK) && step_due && lit;
        status.last = (cnt_reg == BURST_LAST);
        serial_data = shift_reg[BURST_LEN-1];
        latch       = status.last;
    end

    always_comb begin
        fb_next       = fb_reg;
        period_next   = cfg_wr_en ? cfg_wr_data : period_reg;
        elapsed_next  = elapsed_reg;
        byte_idx_next = byte_idx_reg;
        bit_idx_next  = bit_idx_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        shift_next    = shift_reg;
        cnt_next      = cnt_reg;

        if (cmd.shift) begin
            shift_next = {shift_reg[BURST_LEN-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
        end

        if (cmd.exec) begin
            unique case (opcode)
                OP_TICK: begin
                    if (step_due) begin
                        elapsed_next  = '0;
                        byte_idx_next = byte_adv;
                        bit_idx_next  = bit_adv;
                        row_next      = row_step;
                        col_next      = col_step;
                        shift_next    = {col_step, row_step};
                        cnt_next      = '0;
                    end else begin
                        elapsed_next = elapsed_inc;
                    end
                end
                OP_SET: begin
                    if (coord_ok) begin
                        fb_next[wr_byte][wr_bit] = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    if (coord_ok) begin
                        fb_next[wr_byte][wr_bit] = 1'b0;
                    end
                end
                OP_ALL_OFF: begin
                    for (int i = 0; i < MATRIX_DIM; i++) begin
                        fb_next[i] = '0;
                    end
                end
                OP_ALL_ON: begin
                    for (int i = 0; i < MATRIX_DIM; i++) begin
                        fb_next[i] = '1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        if (!aresetn) begin
            for (int i = 0; i < MATRIX_DIM; i++) begin
                fb_reg[i] <= '0;
            end
            period_reg   <= SCAN_PERIOD_RESET;
            elapsed_reg  <= '0;
            byte_idx_reg <= '0;
            bit_idx_reg  <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            cnt_reg      <= '0;
        end else begin
            fb_reg       <= fb_next;
            period_reg   <= period_next;
            elapsed_reg  <= elapsed_next;
            byte_idx_reg <= byte_idx_next;
            bit_idx_reg  <= bit_idx_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hdl/led_matrix_pixel_scanner_core.sv
// Top level of the 8x8 LED matrix pixel scanner.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid / s_tready  s_tuser = opcode, s_tdata = pixel_bit, pixel_byte
//  m_        out  m_tvalid / m_tready  m_tdata = serial_data, m_tlast = latch
//  cfg_      in   cfg_wr_en            cfg_wr_data = scan_period
//
// Input is accepted whenever no burst is in progress. A tick that lands on a
// lit pixel starts a 16-bit burst; input is held off until the 16th output
// transfer has been taken.
// The burst length is set by the single serial shifter in the datapath.
// Reset (aresetn low, synchronous) clears the frame buffer, scan position,
// drive bits and timer, and loads scan_period with 1000.
// Stalls on m_tready simply hold the current burst bit on the output.
`default_nettype none

module led_matrix_pixel_scanner_core
    import lmps_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // config
    input  wire logic                cfg_wr_en,
    input  wire logic [PERIOD_W-1:0] cfg_wr_data,   // scan_period
    // input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,       // [3:0] pixel_bit, [7:4] pixel_byte
    input  wire logic [2:0]          s_tuser,       // [2:0] opcode
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,       // [0] serial_data, [7:1] zero
    output logic                     m_tlast        // latch
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       serial_data;

    // sequencing: accept items, then walk the burst one transfer at a time
    lmps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // frame buffer, timer, scan position and shifter
    lmps_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opcode      (s_tuser),
        .pixel_bit   (s_tdata[3:0]),
        .pixel_byte  (s_tdata[7:4]),
        .cmd         (cmd),
        .status      (status),
        .serial_data (serial_data),
        .latch       (m_tlast)
    );

    assign m_tdata = {7'b0, serial_data};

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the LED matrix pixel scanner core.
`timescale 1ns / 1ps

module testbench
    import lmps_pkg::*;
;

    // One expected output transfer: serial bit plus latch marker.
    typedef struct packed {
        logic serial_data;
        logic latch;
    } scan_bit_t;

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [PERIOD_W-1:0] cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = '0;      // [3:0] pixel_bit, [7:4] pixel_byte
    logic [OPCODE_W-1:0] s_tuser     = OP_TICK; // [2:0] opcode
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [7:0]          m_tdata;               // [0] serial_data, [7:1] zero
    logic                m_tlast;               // latch

    // Shadow of the scanner state, updated on each accepted input transfer.
    logic [7:0]          frame_model [MATRIX_DIM];
    logic [IDX_W-1:0]    scan_row;              // frame byte being scanned
    logic [IDX_W-1:0]    scan_col;              // bit within that byte
    logic [7:0]          row_drive_model;
    logic [7:0]          col_drive_model;
    logic [PERIOD_W-1:0] elapsed_model;
    logic [PERIOD_W-1:0] period_model;

    scan_bit_t pending_bits [$];   // serial bits predicted but not yet seen
    int        mismatches     = 0;

    // Sender pacing: bursts of back-to-back transfers separated by gaps.
    int        burst_left     = 0;
    bit        steady         = 1'b0;  // no gaps while set

    // Receiver stall pattern, rotated every cycle, redrawn now and then.
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_hold  = 0;

    led_matrix_pixel_scanner_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_model();
        foreach (frame_model[i])
            frame_model[i] = 8'h00;
        scan_row        = '0;
        scan_col        = '0;
        row_drive_model = 8'h00;
        col_drive_model = 8'h00;
        elapsed_model   = '0;
        period_model    = SCAN_PERIOD_RESET;
    endfunction

    // One scan step: release old position, advance, drive and shift out if lit.
    function automatic void matrix_scan_step();
        logic [15:0] shift_word;
        row_drive_model[scan_row] = 1'b0;
        col_drive_model[scan_col] = 1'b1;
        scan_col = scan_col + 1'b1;
        if (scan_col == '0)
            scan_row = scan_row + 1'b1;
        if (frame_model[scan_row][scan_col]) begin
            row_drive_model[scan_row] = 1'b1;
            col_drive_model[scan_col] = 1'b0;
            // column byte first, MSB first; latch rides on the final row bit
            shift_word = {col_drive_model, row_drive_model};
            for (int i = 2 * MATRIX_DIM - 1; i >= 0; i--)
                pending_bits.push_back('{serial_data: shift_word[i], latch: (i == 0)});
        end
    endfunction

    function automatic void advance_matrix_model(input logic [OPCODE_W-1:0] op,
                                                 input logic [COORD_W-1:0]  pbit,
                                                 input logic [COORD_W-1:0]  pbyte);
        case (op)
            OP_TICK: begin
                // timer saturates rather than wrapping
                if (elapsed_model != ELAPSED_MAX)
                    elapsed_model = elapsed_model + 1'b1;
                if (elapsed_model > period_model) begin
                    elapsed_model = '0;
                    matrix_scan_step();
                end
            end
            OP_SET, OP_CLEAR: begin
                // 1-based coordinates; anything outside 1..8 is dropped
                if (pbit >= 1 && pbit <= MATRIX_DIM && pbyte >= 1 && pbyte <= MATRIX_DIM)
                    frame_model[pbyte - 1][pbit - 1] = (op == OP_SET);
            end
            OP_ALL_OFF, OP_ALL_ON: begin
                foreach (frame_model[i])
                    frame_model[i] = {8{op == OP_ALL_ON}};
            end
            default: ;  // unused opcodes do nothing
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Present one item and hold it until the transfer completes.
    task automatic send_item(input logic [OPCODE_W-1:0] op,
                             input logic [COORD_W-1:0]  pbit,
                             input logic [COORD_W-1:0]  pbyte);
        int gap;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                @(negedge aclk) s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pbyte, pbit};
        do @(posedge aclk); while (!s_tready);
        advance_matrix_model(op, pbit, pbyte);
    endtask

    // Drop valid, let every predicted bit drain, then let the bench idle so
    // that a step on a dark pixel has settled too.
    task automatic wait_idle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_bits.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        period_model = value;
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    // Receiver: ready follows a rotating pattern; some windows never stall.
    always @(negedge aclk) begin
        if (pattern_hold == 0) begin
            pattern_hold <= $urandom_range(40, 400);
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'($urandom) | 16'h0001;
                2:       ready_pattern <= 16'($urandom | $urandom);
                default: ready_pattern <= 16'($urandom & $urandom) | 16'h0101;
            endcase
        end else begin
            pattern_hold  <= pattern_hold - 1;
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
        end
        m_tready <= ready_pattern[15];
    end

    // ------------------------------------------------------------------
    // Checker: each output transfer against the oldest predicted bit
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        scan_bit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bits.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer: data %02h last %0b",
                                          m_tdata, m_tlast));
            end else begin
                want = pending_bits.pop_front();
                if (m_tdata !== {7'b0, want.serial_data})
                    report_mismatch($sformatf("serial_data: got %02h, want %0b",
                                              m_tdata, want.serial_data));
                if (m_tlast !== want.latch)
                    report_mismatch($sformatf("latch: got %0b, want %0b",
                                              m_tlast, want.latch));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset period of 1000 ticks: a handful of ticks must not step the scan.
    task automatic test_default_period();
        send_item(OP_ALL_ON, 4'd0, 4'd0);
        repeat (8)
            send_item(OP_TICK, COORD_W'($urandom_range(0, 15)),
                      COORD_W'($urandom_range(0, 15)));
    endtask

    // Corners, clears, out-of-range coordinates, unused opcodes, dark steps.
    task automatic test_pixel_ops();
        wait_idle();
        write_period('0);   // every tick steps
        send_item(OP_ALL_OFF, 4'd0, 4'd0);
        send_item(OP_SET, 4'd1, 4'd1);
        send_item(OP_SET, 4'd8, 4'd8);
        send_item(OP_SET, 4'd1, 4'd8);
        send_item(OP_SET, 4'd8, 4'd1);
        send_item(OP_CLEAR, 4'd8, 4'd8);
        send_item(OP_SET, 4'd0, 4'd4);      // out of range, dropped
        send_item(OP_SET, 4'd9, 4'd4);
        send_item(OP_SET, 4'd4, 4'd0);
        send_item(OP_SET, 4'd4, 4'd15);
        send_item(OP_CLEAR, 4'd15, 4'd1);
        for (int op = 5; op < 8; op++)      // unused opcodes
            send_item(OPCODE_W'(op), 4'd3, 4'd3);
        repeat (8) send_item(OP_TICK, 4'd15, 4'd15);   // crosses a lit corner
        send_item(OP_ALL_ON, 4'd0, 4'd0);
        repeat (3) send_item(OP_TICK, 4'd0, 4'd0);
    endtask

    // Period at its top values never steps within a few ticks; then 1.
    task automatic test_period_extremes();
        wait_idle();
        write_period(20'd1000000);
        send_item(OP_ALL_ON, 4'd0, 4'd0);
        repeat (6) send_item(OP_TICK, 4'd0, 4'd0);
        wait_idle();
        write_period(ELAPSED_MAX);
        repeat (6) send_item(OP_TICK, 4'd0, 4'd0);
        wait_idle();
        write_period(20'd1);
        repeat (8) send_item(OP_TICK, 4'd0, 4'd0);
    endtask

    // Mixed traffic: mostly ticks and pixel writes, some malformed items.
    task automatic test_random_traffic();
        int                  sent;
        int                  roll;
        logic [OPCODE_W-1:0] op;
        logic [COORD_W-1:0]  pbit;
        logic [COORD_W-1:0]  pbyte;
        for (sent = 0; sent < 95; sent++) begin
            if (sent % 50 == 0) begin
                wait_idle();
                write_period(PERIOD_W'($urandom_range(0, 3)));
                steady = ($urandom_range(0, 3) == 0);
            end
            roll  = $urandom_range(0, 99);
            pbit  = COORD_W'($urandom_range(1, 8));
            pbyte = COORD_W'($urandom_range(1, 8));
            if (roll < 55) begin
                op    = OP_TICK;
                pbit  = COORD_W'($urandom_range(0, 15));
                pbyte = COORD_W'($urandom_range(0, 15));
            end else if (roll < 70) begin
                op = OP_SET;
            end else if (roll < 82) begin
                op = OP_CLEAR;
            end else if (roll < 86) begin
                op = OP_ALL_ON;
            end else if (roll < 89) begin
                op = OP_ALL_OFF;
            end else if (roll < 95) begin
                // coordinates over the whole field, often out of range
                op    = $urandom_range(0, 1) ? OP_SET : OP_CLEAR;
                pbit  = COORD_W'($urandom_range(0, 15));
                pbyte = COORD_W'($urandom_range(0, 15));
            end else begin
                op    = OPCODE_W'($urandom_range(5, 7));
                pbit  = COORD_W'($urandom_range(0, 15));
                pbyte = COORD_W'($urandom_range(0, 15));
            end
            send_item(op, pbit, pbyte);
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int drain;
        reset_model();
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_default_period();
        test_pixel_ops();
        test_period_extremes();
        test_random_traffic();

        // let the last burst drain, with a bound
        @(negedge aclk) s_tvalid <= 1'b0;
        drain = 0;
        while (pending_bits.size() != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (20) @(posedge aclk);
        if (pending_bits.size() != 0)
            report_mismatch($sformatf("%0d predicted bits never transferred",
                                      pending_bits.size()));

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
